// ===== rtl/core/tod_pkg.sv =====
package tod_pkg;

   localparam int unsigned RAW_W   = 13;
   localparam int unsigned TILTX_W = 14;
   localparam int unsigned MASK_W  = 8;
   localparam int unsigned LIMIT_W = 12;
   localparam int unsigned CSR_ADDR_W = 8;

   localparam logic [15:0] RECIP10     = 16'd52429;
   localparam int unsigned DIV10_SHIFT = 19;

   typedef logic signed [RAW_W-1:0]   raw_type;
   typedef logic signed [TILTX_W-1:0] tiltx_type;
   typedef logic        [RAW_W-1:0]   mag_type;
   typedef logic        [MASK_W-1:0]  mask_type;
   typedef logic        [LIMIT_W-1:0] limit_type;
   typedef logic        [1:0]         orient_type;

   typedef enum logic [2:0] {
      DEC_SKIP   = 3'd0,
      DEC_FAST   = 3'd1,
      DEC_FLAT   = 3'd2,
      DEC_MIDDLE = 3'd3,
      DEC_SET    = 3'd4
   } dec_type;

   localparam orient_type ORIENT_XPOS = 2'd0;
   localparam orient_type ORIENT_YNEG = 2'd1;
   localparam orient_type ORIENT_XNEG = 2'd2;
   localparam orient_type ORIENT_YPOS = 2'd3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DECIMATE_MASK = 8'd0,
      CSR_CHANGE_LIMIT  = 8'd1,
      CSR_FLAT_LIMIT    = 8'd2,
      CSR_DEAD_BAND     = 8'd3
   } csr_index_type;

   function automatic mag_type abs13(input raw_type v);
      return v[RAW_W-1] ? mag_type'(-v) : mag_type'(v);
   endfunction

   // trunc((9*old + raw) / 10), divide by reciprocal multiply on the magnitude
   function automatic raw_type smooth(input raw_type old_v, input raw_type raw_v);
      logic signed [16:0] ext_old;
      logic signed [16:0] ext_raw;
      logic signed [16:0] num;
      logic        [15:0] mag;
      logic        [31:0] prod;
      logic  [RAW_W-1:0]  quo;
      ext_old = {{(17-RAW_W){old_v[RAW_W-1]}}, old_v};
      ext_raw = {{(17-RAW_W){raw_v[RAW_W-1]}}, raw_v};
      num  = (ext_old <<< 3) + ext_old + ext_raw;
      mag  = num[16] ? 16'(-num) : num[15:0];
      prod = 32'(mag) * 32'(RECIP10);
      quo  = prod[DIV10_SHIFT +: RAW_W];
      return num[16] ? raw_type'(-quo) : raw_type'(quo);
   endfunction

endpackage

// ===== rtl/core/tod_if.sv =====
interface tod_req_if;
   logic             valid;
   logic             ready;
   tod_pkg::raw_type raw_x;
   tod_pkg::raw_type raw_y;
   tod_pkg::raw_type raw_z;

   modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
   modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface tod_rsp_if;
   logic                  valid;
   logic                  ready;
   tod_pkg::orient_type   orientation;
   logic            [2:0] decision;
   tod_pkg::tiltx_type    tilt_x;
   tod_pkg::raw_type      tilt_y;
   tod_pkg::raw_type      tilt_z;

   modport source (output valid, output orientation, output decision, output tilt_x,
                   output tilt_y, output tilt_z, input ready);
   modport sink   (input valid, input orientation, input decision, input tilt_x,
                   input tilt_y, input tilt_z, output ready);
endinterface

// ===== rtl/core/tilt_orientation_detector_top.sv =====
// channel  | dir | payload                                        | handshake
// req_ch   | in  | raw_x, raw_y, raw_z                            | valid/ready
// rsp_ch   | out | orientation, decision, tilt_x, tilt_y, tilt_z  | valid/ready
// csr      | in  | csr_index, csr_wdata                           | csr_we, no wait
//
// one beat in, one beat out; the input register takes the beat at acceptance and
// the result register takes it from there once rsp_ch is free and offers the result
// the filter, change, flat and dead band checks sit in the single stage between
// the two registers; one beat per cycle is sustained while rsp_ch.ready is high
// a stalled result holds the result register; one more beat can wait in the
// input register, then req_ch.ready drops
// reset is synchronous and restores the valid flags, the CSRs and the filter state to their defaults
module tilt_orientation_detector_top (
   input  logic                               clock,
   input  logic                               reset,
   tod_req_if.sink                            req_ch,
   tod_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [tod_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [tod_pkg::LIMIT_W-1:0]        csr_wdata
);
   import tod_pkg::*;

   mask_type   decimate_mask_ff;
   limit_type  change_limit_ff;
   limit_type  flat_limit_ff;
   limit_type  dead_band_ff;

   logic       in_valid_ff;
   raw_type    in_raw_x_ff;
   raw_type    in_raw_y_ff;
   raw_type    in_raw_z_ff;

   logic [MASK_W-1:0] frame_count_ff;
   logic [MASK_W-1:0] frame_count_in;
   logic       have_sample_ff;
   raw_type    filt_x_ff;
   raw_type    filt_y_ff;
   raw_type    filt_z_ff;
   raw_type    filt_x_in;
   raw_type    filt_y_in;
   raw_type    filt_z_in;
   orient_type orient_ff;
   orient_type orient_in;

   logic       rsp_valid_ff;
   orient_type rsp_orient_ff;
   dec_type    rsp_decision_ff;
   dec_type    decision_in;
   tiltx_type  rsp_tilt_x_ff;
   raw_type    rsp_tilt_y_ff;
   raw_type    rsp_tilt_z_ff;

   logic       out_free;
   logic       advance;
   logic       take;
   logic       moved;
   mag_type    ax_old, ay_old, az_old;
   mag_type    ax_new, ay_new, az_new;
   mag_type    dx, dy, dz;
   mag_type    mag_tx, mag_ty;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.orientation = rsp_orient_ff;
   assign rsp_ch.decision    = rsp_decision_ff;
   assign rsp_ch.tilt_x      = rsp_tilt_x_ff;
   assign rsp_ch.tilt_y      = rsp_tilt_y_ff;
   assign rsp_ch.tilt_z      = rsp_tilt_z_ff;

   always_comb begin
      frame_count_in = frame_count_ff + 1'b1;
      take           = (frame_count_in & decimate_mask_ff) == '0;

      if (have_sample_ff) begin
         filt_x_in = smooth(filt_x_ff, in_raw_x_ff);
         filt_y_in = smooth(filt_y_ff, in_raw_y_ff);
         filt_z_in = smooth(filt_z_ff, in_raw_z_ff);
      end else begin
         filt_x_in = in_raw_x_ff;
         filt_y_in = in_raw_y_ff;
         filt_z_in = in_raw_z_ff;
      end

      ax_old = abs13(filt_x_ff);
      ay_old = abs13(filt_y_ff);
      az_old = abs13(filt_z_ff);
      ax_new = abs13(filt_x_in);
      ay_new = abs13(filt_y_in);
      az_new = abs13(filt_z_in);
      dx = (ax_new > ax_old) ? ax_new - ax_old : ax_old - ax_new;
      dy = (ay_new > ay_old) ? ay_new - ay_old : ay_old - ay_new;
      dz = (az_new > az_old) ? az_new - az_old : az_old - az_new;
      moved = (dx > mag_type'(change_limit_ff)) || (dy > mag_type'(change_limit_ff))
           || (dz > mag_type'(change_limit_ff));

      // rotated frame: tilt_x = -filt_y, tilt_y = filt_x
      mag_tx = ay_new;
      mag_ty = ax_new;

      orient_in   = orient_ff;
      decision_in = DEC_SKIP;
      if (take) begin
         if (moved) begin
            decision_in = DEC_FAST;
         end else if (az_new > mag_type'(flat_limit_ff)) begin
            decision_in = DEC_FLAT;
         end else if (mag_tx > mag_ty) begin
            if ((mag_tx - mag_ty) < mag_type'(dead_band_ff)) begin
               decision_in = DEC_MIDDLE;
            end else begin
               decision_in = DEC_SET;
               orient_in   = (filt_y_in > 0) ? ORIENT_XNEG : ORIENT_XPOS;
            end
         end else begin
            if ((mag_ty - mag_tx) < mag_type'(dead_band_ff)) begin
               decision_in = DEC_MIDDLE;
            end else begin
               decision_in = DEC_SET;
               orient_in   = filt_x_in[RAW_W-1] ? ORIENT_YNEG : ORIENT_YPOS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decimate_mask_ff <= MASK_W'(3);
         change_limit_ff  <= LIMIT_W'(100);
         flat_limit_ff    <= LIMIT_W'(900);
         dead_band_ff     <= LIMIT_W'(100);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DECIMATE_MASK: decimate_mask_ff <= csr_wdata[MASK_W-1:0];
            CSR_CHANGE_LIMIT:  change_limit_ff  <= csr_wdata;
            CSR_FLAT_LIMIT:    flat_limit_ff    <= csr_wdata;
            CSR_DEAD_BAND:     dead_band_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_raw_x_ff <= req_ch.raw_x;
         in_raw_y_ff <= req_ch.raw_y;
         in_raw_z_ff <= req_ch.raw_z;
      end
   end

   // filter and orientation state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         have_sample_ff <= 1'b0;
         filt_x_ff      <= '0;
         filt_y_ff      <= '0;
         filt_z_ff      <= '0;
         orient_ff      <= ORIENT_XPOS;
      end else if (advance) begin
         frame_count_ff <= frame_count_in;
         orient_ff      <= orient_in;
         if (take) begin
            have_sample_ff <= 1'b1;
            filt_x_ff      <= filt_x_in;
            filt_y_ff      <= filt_y_in;
            filt_z_ff      <= filt_z_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_orient_ff   <= orient_in;
         rsp_decision_ff <= decision_in;
         if (take) begin
            rsp_tilt_x_ff <= -{filt_y_in[RAW_W-1], filt_y_in};
            rsp_tilt_y_ff <= filt_x_in;
            rsp_tilt_z_ff <= filt_z_in;
         end else begin
            rsp_tilt_x_ff <= -{filt_y_ff[RAW_W-1], filt_y_ff};
            rsp_tilt_y_ff <= filt_x_ff;
            rsp_tilt_z_ff <= filt_z_ff;
         end
      end
   end

   // skipped tick leaves the filter state alone
   assert property (@(posedge clock) disable iff (reset)
      (advance && !take) |=> ($stable(filt_x_ff) && $stable(filt_y_ff) && $stable(filt_z_ff)
                              && $stable(orient_ff)))
      else $error("filter state changed on a skipped tick");

   // a beat in the input register is never dropped while the result is stalled
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> in_valid_ff)
      else $error("input beat lost during stall");

   assert property (@(posedge clock) disable iff (reset)
      have_sample_ff |=> have_sample_ff)
      else $error("sample flag cleared outside reset");

   // orientation set agrees with the sign of the dominant axis
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_decision_ff == DEC_SET) |->
         ((rsp_orient_ff == ORIENT_XPOS && rsp_tilt_x_ff > 0)
       || (rsp_orient_ff == ORIENT_XNEG && rsp_tilt_x_ff < 0)
       || (rsp_orient_ff == ORIENT_YNEG && rsp_tilt_y_ff < 0)
       || (rsp_orient_ff == ORIENT_YPOS && rsp_tilt_y_ff >= 0)))
      else $error("orientation does not match tilt sign");

endmodule
